### hdl/lgfm_pkg.sv
// Package for the line and ground fault monitor.
// Holds the shared state codes, register indexes and the item, result and configuration types.
// No dependencies.
`timescale 1ns / 1ps

package lgfm_pkg;

  // Converter and scaling constants: millivolts = (code * full scale mV) >> converter bits.
  localparam int unsigned ADC_BITS    = 12;
  localparam int unsigned MV_BITS     = 12;
  localparam int unsigned FULL_MV     = 3300;
  localparam int unsigned PROD_BITS   = 2 * ADC_BITS;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned SPAN_BITS   = 16;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_DATA_BITS  = 48;
  localparam int unsigned OUT_DATA_BITS = 24;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] CFG_STANDARD_MODE     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_MIN_MV    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_MAX_MV    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_MIN_MV       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_OPEN_MAX_MV       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_FILTER_MS = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REVERSE_MAX_MS    = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GROUND_FILTER_MS  = 3'd7;

  typedef enum logic [1:0] {
    LS_UNKNOWN  = 2'd0,
    LS_NORMAL   = 2'd1,
    LS_REVERSED = 2'd2
  } line_state_e;

  typedef enum logic [1:0] {
    GS_UNKNOWN   = 2'd0,
    GS_CONNECTED = 2'd1,
    GS_OPEN      = 2'd2
  } ground_state_e;

  typedef struct packed {
    logic                 standard_mode;
    logic [MV_BITS-1:0]   reverse_min_mv;
    logic [MV_BITS-1:0]   reverse_max_mv;
    logic [MV_BITS-1:0]   open_min_mv;
    logic [MV_BITS-1:0]   open_max_mv;
    logic [SPAN_BITS-1:0] reverse_filter_ms;
    logic [SPAN_BITS-1:0] reverse_max_ms;
    logic [SPAN_BITS-1:0] ground_filter_ms;
  } cfg_t;

  typedef struct packed {
    logic                 pilot_at_12v;
    logic [TIME_BITS-1:0] now_ms;
    logic [ADC_BITS-1:0]  adc_code;
  } item_t;

  typedef struct packed {
    logic [MV_BITS-1:0] sense_mv;
    logic               clear_ground_break;
    logic               raise_ground_break;
    logic               raise_reversed;
    logic               ground_fault;
    ground_state_e      ground_state;
    line_state_e        line_state;
  } result_t;

endpackage

### hdl/lgfm_cfg.sv
// Configuration register bank of the line and ground fault monitor.
// Depends on lgfm_pkg for the register indexes and the cfg_t type.
`timescale 1ns / 1ps

module lgfm_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lgfm_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [lgfm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  output lgfm_pkg::cfg_t                      cfg_o
);
  import lgfm_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STANDARD_MODE:     cfg_d.standard_mode     = cfg_wdata_i[0];
        CFG_REVERSE_MIN_MV:    cfg_d.reverse_min_mv    = cfg_wdata_i[MV_BITS-1:0];
        CFG_REVERSE_MAX_MV:    cfg_d.reverse_max_mv    = cfg_wdata_i[MV_BITS-1:0];
        CFG_OPEN_MIN_MV:       cfg_d.open_min_mv       = cfg_wdata_i[MV_BITS-1:0];
        CFG_OPEN_MAX_MV:       cfg_d.open_max_mv       = cfg_wdata_i[MV_BITS-1:0];
        CFG_REVERSE_FILTER_MS: cfg_d.reverse_filter_ms = cfg_wdata_i[SPAN_BITS-1:0];
        CFG_REVERSE_MAX_MS:    cfg_d.reverse_max_ms    = cfg_wdata_i[SPAN_BITS-1:0];
        CFG_GROUND_FILTER_MS:  cfg_d.ground_filter_ms  = cfg_wdata_i[SPAN_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/lgfm_core.sv
// Decision logic of the line and ground fault monitor: scaling, window compares,
// debounce timers and the fault latch. Depends on lgfm_pkg.
`timescale 1ns / 1ps

module lgfm_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  lgfm_pkg::item_t     item_i,
  input  lgfm_pkg::cfg_t      cfg_i,
  output lgfm_pkg::result_t   result_o
);
  import lgfm_pkg::*;

  // True once span milliseconds have passed since start, modulo the timestamp wrap.
  function automatic logic elapsed(input logic [TIME_BITS-1:0] now,
                                   input logic [TIME_BITS-1:0] start,
                                   input logic [SPAN_BITS-1:0] span);
    logic [TIME_BITS-1:0] diff;
    diff = now - start;
    return diff >= {{(TIME_BITS-SPAN_BITS){1'b0}}, span};
  endfunction

  line_state_e          line_acc_q, line_acc_d;
  line_state_e          line_cand_q, line_cand_d;
  ground_state_e        gnd_acc_q, gnd_acc_d;
  ground_state_e        gnd_cand_q, gnd_cand_d;
  logic                 fault_q, fault_d;
  logic                 check_done_q, check_done_d;
  logic                 check_armed_q, check_armed_d;
  logic [TIME_BITS-1:0] check_start_q, check_start_d;
  logic [TIME_BITS-1:0] filter_start_q, filter_start_d;

  logic [PROD_BITS-1:0] prod;
  logic [MV_BITS-1:0]   mv;
  line_state_e          line_cur;
  ground_state_e        gnd_cur;
  logic                 raise_rev;
  logic                 raise_set;
  logic                 raise_clr;

  assign prod = {{(PROD_BITS-ADC_BITS){1'b0}}, item_i.adc_code} * PROD_BITS'(FULL_MV);
  assign mv   = prod[PROD_BITS-1:ADC_BITS];

  assign line_cur = (mv >= cfg_i.reverse_min_mv && mv <= cfg_i.reverse_max_mv)
                    ? LS_REVERSED : LS_NORMAL;
  assign gnd_cur  = (mv >= cfg_i.open_min_mv && mv <= cfg_i.open_max_mv)
                    ? GS_OPEN : GS_CONNECTED;

  always_comb begin
    line_acc_d     = line_acc_q;
    line_cand_d    = line_cand_q;
    gnd_acc_d      = gnd_acc_q;
    gnd_cand_d     = gnd_cand_q;
    fault_d        = fault_q;
    check_done_d   = check_done_q;
    check_armed_d  = check_armed_q;
    check_start_d  = check_start_q;
    filter_start_d = filter_start_q;
    raise_rev      = 1'b0;
    raise_set      = 1'b0;
    raise_clr      = 1'b0;

    // Line and neutral orientation check, runs until a decision is made.
    if (!cfg_i.standard_mode && !check_done_q) begin
      if (line_cand_q != line_cur) begin
        line_cand_d    = line_cur;
        filter_start_d = item_i.now_ms;
      end else if (elapsed(item_i.now_ms, filter_start_q, cfg_i.reverse_filter_ms)) begin
        line_acc_d = line_cur;
      end
      if (line_acc_d != LS_UNKNOWN) begin
        check_done_d = 1'b1;
        raise_rev    = (line_acc_d == LS_REVERSED);
      end else begin
        if (!check_armed_q) begin
          check_armed_d = 1'b1;
          check_start_d = item_i.now_ms;
        end
        if (elapsed(item_i.now_ms, check_start_d, cfg_i.reverse_max_ms)) begin
          line_acc_d   = LS_NORMAL;
          check_done_d = 1'b1;
        end
      end
    end else if (cfg_i.standard_mode && line_acc_q == LS_REVERSED) begin
      line_acc_d = LS_UNKNOWN;
      raise_rev  = 1'b1;
    end

    // Ground continuity check, only with a normal line.
    if (!cfg_i.standard_mode && check_done_d) begin
      if (line_acc_d == LS_NORMAL) begin
        if (gnd_cand_q != gnd_cur) begin
          gnd_cand_d     = gnd_cur;
          filter_start_d = item_i.now_ms;
        end else if (elapsed(item_i.now_ms, filter_start_d, cfg_i.ground_filter_ms)) begin
          if (gnd_cur != gnd_acc_q) begin
            gnd_acc_d = gnd_cur;
            if (gnd_cur == GS_OPEN && !fault_q) begin
              fault_d   = 1'b1;
              raise_set = 1'b1;
            end
          end
          if (gnd_cur == GS_CONNECTED && fault_d && item_i.pilot_at_12v) begin
            fault_d   = 1'b0;
            raise_clr = 1'b1;
          end
        end
      end
    end else if (fault_q) begin
      fault_d    = 1'b0;
      gnd_acc_d  = GS_UNKNOWN;
      gnd_cand_d = GS_UNKNOWN;
      raise_clr  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_acc_q     <= LS_UNKNOWN;
      line_cand_q    <= LS_UNKNOWN;
      gnd_acc_q      <= GS_UNKNOWN;
      gnd_cand_q     <= GS_UNKNOWN;
      fault_q        <= 1'b0;
      check_done_q   <= 1'b0;
      check_armed_q  <= 1'b0;
      check_start_q  <= '0;
      filter_start_q <= '0;
    end else if (step_i) begin
      line_acc_q     <= line_acc_d;
      line_cand_q    <= line_cand_d;
      gnd_acc_q      <= gnd_acc_d;
      gnd_cand_q     <= gnd_cand_d;
      fault_q        <= fault_d;
      check_done_q   <= check_done_d;
      check_armed_q  <= check_armed_d;
      check_start_q  <= check_start_d;
      filter_start_q <= filter_start_d;
    end
  end

  always_comb begin
    result_o.line_state         = line_acc_d;
    result_o.ground_state       = gnd_acc_d;
    result_o.ground_fault       = fault_d;
    result_o.raise_reversed     = raise_rev;
    result_o.raise_ground_break = raise_set;
    result_o.clear_ground_break = raise_clr;
    result_o.sense_mv           = mv;
  end

endmodule

### hdl/line_and_ground_fault_monitor_top.sv
// Top level of the line and ground fault monitor: stream ports, input and result registers.
// Depends on lgfm_pkg, lgfm_cfg and lgfm_core.
`timescale 1ns / 1ps

// The monitor takes one sample request per clock cycle while the result stream is not
// stalled and returns exactly one result request for each, in order. A request passes an
// input register, the decision logic and a result register, from which its result is
// offered on the result stream. A full stream runs at one request per cycle when the
// receiver never stalls; the rate rests on the decision logic, which updates its state
// on each step from the state the previous sample left behind.
// Each sample is scaled to millivolts as (code * 3300) >> 12. Outside standard mode the
// block first decides whether line and neutral are reversed, using a window compare that
// must hold for the reverse filter time; if no decision is reached within the maximum
// check time the line is taken as normal. With a normal line the ground is then judged
// connected or open through a second window and the ground filter time; an accepted open
// ground latches a fault, which clears once the ground is connected again while the pilot
// reads 12V. Both filters share one start timestamp. Timestamps wrap modulo 2^32, and a
// filter time of zero counts as elapsed at once. Standard mode clears the fault and any
// reversal; the line check, once finished, is not restarted until reset. Configuration
// registers should be written only while no request is in flight.
module line_and_ground_fault_monitor_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration write port.
  input  logic                                 cfg_we_i,
  input  logic [lgfm_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [lgfm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata_i,
  // Sample stream.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0 up: adc_code[11:0], now_ms[43:12], pilot_at_12v[44], zero pad[47:45].
  input  logic [lgfm_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // Result stream.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0 up: line_state[1:0], ground_state[3:2], ground_fault[4],
  // raise_reversed[5], raise_ground_break[6], clear_ground_break[7], sense_mv[19:8],
  // zero pad[23:20].
  output logic [lgfm_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
  import lgfm_pkg::*;

  localparam int unsigned ITEM_BITS   = $bits(item_t);
  localparam int unsigned RESULT_BITS = $bits(result_t);

  cfg_t    cfg;
  result_t result;

  logic    in_valid_q, in_valid_d;
  item_t   in_item_q;
  logic    out_valid_q, out_valid_d;
  result_t out_res_q;
  logic    in_fire;
  logic    step;

  // The stored sample is processed when the result register is free or being emptied.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_item_q <= item_t'(s_axis_tdata[ITEM_BITS-1:0]);
    end
    if (step) begin
      out_res_q <= result;
    end
  end

  lgfm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lgfm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_BITS-RESULT_BITS){1'b0}}, out_res_q};

  // A fault can only be set and cleared on separate requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.raise_ground_break && out_res_q.clear_ground_break))
    else $error("fault set and cleared in the same result");

  // The event pulses agree with the latched fault they report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((!out_res_q.raise_ground_break || out_res_q.ground_fault) &&
                     (!out_res_q.clear_ground_break || !out_res_q.ground_fault)))
    else $error("fault pulse disagrees with latched fault");

  // A latched fault exists only while the line is judged normal.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_res_q.ground_fault) |-> (out_res_q.line_state == LS_NORMAL))
    else $error("ground fault latched without a normal line");

  // A result that is not taken stays in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_res_q)))
    else $error("stalled result was lost or changed");

endmodule

### tb/lgfm_checker.sv
// Scoreboard for the line and ground fault monitor: predicts one result per accepted sample.
// Watches the configuration port and both stream channels; depends on lgfm_pkg only.
`timescale 1ns / 1ps

module lgfm_checker
  import lgfm_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     s_tvalid_i,
  input  logic                     s_tready_i,
  input  logic [IN_DATA_BITS-1:0]  s_tdata_i,
  input  logic                     m_tvalid_i,
  input  logic                     m_tready_i,
  input  logic [OUT_DATA_BITS-1:0] m_tdata_i,
  output int                       pending_o,
  output int                       compared_o,
  output int                       mismatches_o
);

  localparam int PRINT_CAP = 40;

  cfg_t                 settings;
  line_state_e          line_decided;
  line_state_e          line_guess;
  ground_state_e        ground_decided;
  ground_state_e        ground_guess;
  logic                 fault_held;
  logic                 line_settled;
  logic                 check_armed;
  logic [TIME_BITS-1:0] check_start_ms;
  logic [TIME_BITS-1:0] filter_start_ms;

  result_t              awaited_reports[$];
  item_t                probe;
  result_t              seen;
  result_t              want;

  function automatic logic has_elapsed(input logic [TIME_BITS-1:0] stamp,
                                       input logic [TIME_BITS-1:0] origin,
                                       input logic [SPAN_BITS-1:0] span);
    logic [TIME_BITS-1:0] diff;
    diff = stamp - origin;
    return diff >= {{(TIME_BITS - SPAN_BITS){1'b0}}, span};
  endfunction

  // Advances the monitor state by one sample and returns the report it should produce.
  function automatic result_t step_fault_monitor(input item_t s);
    result_t              r;
    logic [PROD_BITS-1:0] product;
    logic [MV_BITS-1:0]   mv;
    line_state_e          line_now;
    ground_state_e        ground_now;
    r       = '0;
    product = PROD_BITS'(s.adc_code) * PROD_BITS'(FULL_MV);
    mv      = product[PROD_BITS-1 -: MV_BITS];

    if (!settings.standard_mode && !line_settled) begin
      line_now = (mv >= settings.reverse_min_mv && mv <= settings.reverse_max_mv) ?
                 LS_REVERSED : LS_NORMAL;
      if (line_guess != line_now) begin
        line_guess      = line_now;
        filter_start_ms = s.now_ms;
      end else if (has_elapsed(s.now_ms, filter_start_ms, settings.reverse_filter_ms)) begin
        line_decided = line_now;
      end
      if (line_decided != LS_UNKNOWN) begin
        line_settled = 1'b1;
        if (line_decided == LS_REVERSED) r.raise_reversed = 1'b1;
      end else begin
        if (!check_armed) begin
          check_armed    = 1'b1;
          check_start_ms = s.now_ms;
        end
        if (has_elapsed(s.now_ms, check_start_ms, settings.reverse_max_ms)) begin
          line_decided = LS_NORMAL;
          line_settled = 1'b1;
        end
      end
    end else if (settings.standard_mode && line_decided == LS_REVERSED) begin
      line_decided     = LS_UNKNOWN;
      r.raise_reversed = 1'b1;
    end

    if (!settings.standard_mode && line_settled) begin
      if (line_decided == LS_NORMAL) begin
        ground_now = (mv >= settings.open_min_mv && mv <= settings.open_max_mv) ?
                     GS_OPEN : GS_CONNECTED;
        if (ground_guess != ground_now) begin
          ground_guess    = ground_now;
          filter_start_ms = s.now_ms;
        end else if (has_elapsed(s.now_ms, filter_start_ms, settings.ground_filter_ms)) begin
          if (ground_now != ground_decided) begin
            ground_decided = ground_now;
            if (ground_now == GS_OPEN && !fault_held) begin
              fault_held           = 1'b1;
              r.raise_ground_break = 1'b1;
            end
          end
          if (ground_now == GS_CONNECTED && fault_held && s.pilot_at_12v) begin
            fault_held           = 1'b0;
            r.clear_ground_break = 1'b1;
          end
        end
      end
    end else if (fault_held) begin
      fault_held           = 1'b0;
      ground_decided       = GS_UNKNOWN;
      ground_guess         = GS_UNKNOWN;
      r.clear_ground_break = 1'b1;
    end

    r.line_state   = line_decided;
    r.ground_state = ground_decided;
    r.ground_fault = fault_held;
    r.sense_mv     = mv;
    return r;
  endfunction

  // Printing stops after a few dozen lines so a badly broken block cannot flood the log.
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] expected);
    if (mismatches_o < PRINT_CAP) begin
      $display("%0t ps: result %0d, %s: got %0d, expected %0d",
               $time, compared_o, what, got, expected);
    end
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings        = '0;
      line_decided    = LS_UNKNOWN;
      line_guess      = LS_UNKNOWN;
      ground_decided  = GS_UNKNOWN;
      ground_guess    = GS_UNKNOWN;
      fault_held      = 1'b0;
      line_settled    = 1'b0;
      check_armed     = 1'b0;
      check_start_ms  = '0;
      filter_start_ms = '0;
      awaited_reports.delete();
      pending_o       = 0;
      compared_o      = 0;
      mismatches_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STANDARD_MODE:     settings.standard_mode     = cfg_wdata_i[0];
          CFG_REVERSE_MIN_MV:    settings.reverse_min_mv    = cfg_wdata_i[MV_BITS-1:0];
          CFG_REVERSE_MAX_MV:    settings.reverse_max_mv    = cfg_wdata_i[MV_BITS-1:0];
          CFG_OPEN_MIN_MV:       settings.open_min_mv       = cfg_wdata_i[MV_BITS-1:0];
          CFG_OPEN_MAX_MV:       settings.open_max_mv       = cfg_wdata_i[MV_BITS-1:0];
          CFG_REVERSE_FILTER_MS: settings.reverse_filter_ms = cfg_wdata_i[SPAN_BITS-1:0];
          CFG_REVERSE_MAX_MS:    settings.reverse_max_ms    = cfg_wdata_i[SPAN_BITS-1:0];
          CFG_GROUND_FILTER_MS:  settings.ground_filter_ms  = cfg_wdata_i[SPAN_BITS-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        probe = s_tdata_i[$bits(item_t)-1:0];
        awaited_reports.push_back(step_fault_monitor(probe));
      end
      if (m_tvalid_i && m_tready_i) begin
        seen = m_tdata_i[$bits(result_t)-1:0];
        if (awaited_reports.size() == 0) begin
          note_mismatch("result with no sample outstanding", m_tdata_i, 0);
        end else begin
          want = awaited_reports.pop_front();
          if (seen.line_state !== want.line_state)
            note_mismatch("line_state", seen.line_state, want.line_state);
          if (seen.ground_state !== want.ground_state)
            note_mismatch("ground_state", seen.ground_state, want.ground_state);
          if (seen.ground_fault !== want.ground_fault)
            note_mismatch("ground_fault", seen.ground_fault, want.ground_fault);
          if (seen.raise_reversed !== want.raise_reversed)
            note_mismatch("raise_reversed", seen.raise_reversed, want.raise_reversed);
          if (seen.raise_ground_break !== want.raise_ground_break)
            note_mismatch("raise_ground_break", seen.raise_ground_break,
                          want.raise_ground_break);
          if (seen.clear_ground_break !== want.clear_ground_break)
            note_mismatch("clear_ground_break", seen.clear_ground_break,
                          want.clear_ground_break);
          if (seen.sense_mv !== want.sense_mv)
            note_mismatch("sense_mv", seen.sense_mv, want.sense_mv);
        end
        compared_o++;
      end
      pending_o = awaited_reports.size();
    end
  end

endmodule

### tb/tb_top.sv
// Testbench top for the line and ground fault monitor: clock, reset, stimulus and verdict.
// Depends on lgfm_pkg, line_and_ground_fault_monitor_top and lgfm_checker.
`timescale 1ns / 1ps

module tb_top;
  import lgfm_pkg::*;

  localparam int          RESET_CYCLES    = 11;
  localparam int          NUM_PHASES      = 8;
  localparam int          PHASE_ITEMS     = 130;
  localparam int          STANDARD_PHASE  = 4;
  localparam int          HOLD_PHASE      = 6;
  localparam int          HOLD_OFF_CYCLES = 120;
  // The block offers a result once its request has passed the input and result registers;
  // the settle wait covers that with margin.
  localparam int          SETTLE_CYCLES   = 6;
  // The slowest correct stretch without any accepted request is the long receiver hold-off
  // plus a sender gap; the limit is many times that.
  localparam int          WATCHDOG_LIMIT  = 3000;
  localparam int unsigned MV_TOP          = 3300;
  localparam int unsigned CODE_TOP        = (1 << ADC_BITS) - 1;

  // Reversed-line window used while the line is being judged, and the codes at its edges.
  localparam int unsigned REV_LO_MV   = 1000;
  localparam int unsigned REV_HI_MV   = 2000;
  localparam int unsigned REV_LO_CODE = (REV_LO_MV * 4096 + FULL_MV - 1) / FULL_MV;
  localparam int unsigned REV_HI_CODE = ((REV_HI_MV + 1) * 4096 - 1) / FULL_MV;
  localparam int unsigned REV_MID_CODE = (REV_LO_CODE + REV_HI_CODE) / 2;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  int                       pending_results;
  int                       compared_results;
  int                       failures;

  // Stimulus bookkeeping shared by the sender and receiver processes.
  logic [TIME_BITS-1:0]     stamp_ms;
  int                       samples_sent;
  int                       quiet_cycles;
  bit                       calm;
  bit                       hold_off_req;
  bit                       settle_reversed;

  line_and_ground_fault_monitor_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lgfm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .pending_o    (pending_results),
    .compared_o   (compared_results),
    .mismatches_o (failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Every task below is entered and left at a falling edge, where all inputs change.

  task automatic put_reg(input logic [CFG_IDX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  // Writes the whole register set. The write enable stays high across the burst and drops
  // after the last register.
  task automatic load_settings(input cfg_t c);
    put_reg(CFG_STANDARD_MODE, CFG_DATA_BITS'(c.standard_mode));
    put_reg(CFG_REVERSE_MIN_MV, CFG_DATA_BITS'(c.reverse_min_mv));
    put_reg(CFG_REVERSE_MAX_MV, CFG_DATA_BITS'(c.reverse_max_mv));
    put_reg(CFG_OPEN_MIN_MV, CFG_DATA_BITS'(c.open_min_mv));
    put_reg(CFG_OPEN_MAX_MV, CFG_DATA_BITS'(c.open_max_mv));
    put_reg(CFG_REVERSE_FILTER_MS, CFG_DATA_BITS'(c.reverse_filter_ms));
    put_reg(CFG_REVERSE_MAX_MS, CFG_DATA_BITS'(c.reverse_max_ms));
    put_reg(CFG_GROUND_FILTER_MS, CFG_DATA_BITS'(c.ground_filter_ms));
    cfg_we_i <= 1'b0;
  endtask

  // Offers one sample request and holds it until the block takes it. Outside the calm part
  // the request is sometimes preceded by an idle burst.
  task automatic send_sample(input logic [ADC_BITS-1:0] code,
                             input logic [TIME_BITS-1:0] stamp,
                             input logic pilot);
    item_t req;
    req.adc_code     = code;
    req.now_ms       = stamp;
    req.pilot_at_12v = pilot;
    if (!calm && $urandom_range(5, 0) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(16, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_BITS'(req);
    do @(posedge clk_i); while (!s_axis_tready);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // The sender stops and waits until every result has come back, so that registers can be
  // rewritten with nothing in flight.
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Picks a converter code whose millivolt value falls inside or outside [lo, hi]. When the
  // window holds no code at all, any code will do.
  function automatic logic [ADC_BITS-1:0] pick_code(input int unsigned lo,
                                                    input int unsigned hi,
                                                    input bit in_window);
    int unsigned lo_code;
    int unsigned hi_code;
    lo_code = (lo * 4096 + FULL_MV - 1) / FULL_MV;
    hi_code = ((hi + 1) * 4096 - 1) / FULL_MV;
    if (hi_code > CODE_TOP) hi_code = CODE_TOP;
    if (lo_code > hi_code) return $urandom_range(CODE_TOP, 0);
    if (in_window) return $urandom_range(hi_code, lo_code);
    if (lo_code > 0 && (hi_code == CODE_TOP || $urandom_range(1, 0) == 1))
      return $urandom_range(lo_code - 1, 0);
    if (hi_code < CODE_TOP) return $urandom_range(CODE_TOP, hi_code + 1);
    return $urandom_range(CODE_TOP, 0);
  endfunction

  // Register set for one random phase. A few phases pin the extremes: a window covering the
  // whole range with zero filter times, maximum filter times with an inverted window, an
  // empty open-ground window, standard mode, and a window of a single millivolt.
  function automatic cfg_t pick_settings(input int phase);
    cfg_t        c;
    int unsigned lo;
    int unsigned hi;
    lo                  = $urandom_range(MV_TOP, 0);
    hi                  = $urandom_range(MV_TOP, lo);
    c.standard_mode     = (phase == STANDARD_PHASE);
    c.reverse_min_mv    = $urandom_range(MV_TOP, 0);
    c.reverse_max_mv    = $urandom_range(MV_TOP, 0);
    c.open_min_mv       = lo;
    c.open_max_mv       = hi;
    c.reverse_filter_ms = $urandom();
    c.reverse_max_ms    = $urandom();
    c.ground_filter_ms  = $urandom_range(25, 1);
    case (phase)
      1: begin
        c.open_min_mv       = 0;
        c.open_max_mv       = MV_TOP;
        c.reverse_min_mv    = 0;
        c.reverse_max_mv    = MV_TOP;
        c.reverse_filter_ms = 0;
        c.reverse_max_ms    = 0;
        c.ground_filter_ms  = 0;
      end
      2: begin
        c.reverse_min_mv    = MV_TOP;
        c.reverse_max_mv    = 0;
        c.reverse_filter_ms = '1;
        c.reverse_max_ms    = '1;
        c.ground_filter_ms  = '1;
      end
      3: begin
        c.open_min_mv = MV_TOP;
        c.open_max_mv = 0;
      end
      5: c.open_max_mv = lo;
      default: ;
    endcase
    return c;
  endfunction

  // Most bursts are runs of one ground class with a steady time stride, which is what gets
  // decisions through the filter; the rest are noise with random codes and timestamps that
  // may jump anywhere, backwards and across the wrap too.
  task automatic send_burst(input cfg_t c);
    int unsigned len;
    int unsigned stride;
    bit          open_side;
    logic        pilot;
    if ($urandom_range(4, 0) == 0) begin
      len = $urandom_range(3, 1);
      repeat (len) begin
        stamp_ms = ($urandom_range(1, 0) == 1) ? $urandom() :
                   stamp_ms + $urandom_range(70000, 0);
        send_sample($urandom_range(CODE_TOP, 0), stamp_ms, $urandom_range(1, 0));
      end
    end else begin
      len       = $urandom_range(12, 1);
      stride    = (c.ground_filter_ms > 100) ? $urandom_range(40000, 0) : $urandom_range(6, 0);
      open_side = $urandom_range(1, 0);
      pilot     = ($urandom_range(3, 0) != 0);
      repeat (len) begin
        stamp_ms = stamp_ms + stride;
        if ($urandom_range(7, 0) == 0) pilot = ~pilot;
        send_sample(pick_code(c.open_min_mv, c.open_max_mv, open_side), stamp_ms, pilot);
      end
    end
  endtask

  // Receiver: alternates ready and stall bursts, and on request holds off for a long stretch
  // so that the block fills up and stops taking samples.
  initial begin
    int unsigned run;
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        run = HOLD_OFF_CYCLES;
      end else if (!calm && $urandom_range(3, 0) == 0) begin
        m_axis_tready <= 1'b0;
        run = $urandom_range(16, 1);
      end else begin
        m_axis_tready <= 1'b1;
        run = $urandom_range(24, 1);
      end
      repeat (run) @(negedge clk_i);
    end
  end

  // Watchdog: ends the run when nothing at all moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_t plan;
    int   phase;
    int   phase_start;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_STANDARD_MODE;
    cfg_wdata_i     = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    m_axis_tready   = 1'b0;
    calm            = 1'b0;
    hold_off_req    = 1'b0;
    samples_sent    = 0;
    quiet_cycles    = 0;
    // The line check runs once per reset and a reversed line blocks the ground check for
    // good, so each run takes one of the two ways; the seed decides which.
    settle_reversed = ($urandom_range(3, 0) == 0);
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Line check phase: reversed window in the middle of the range, a 30 ms line filter and
    // a 200 ms check limit; the open-ground window covers the top of the range.
    plan.standard_mode     = 1'b0;
    plan.reverse_min_mv    = REV_LO_MV;
    plan.reverse_max_mv    = REV_HI_MV;
    plan.open_min_mv       = 2500;
    plan.open_max_mv       = MV_TOP;
    plan.reverse_filter_ms = 30;
    plan.reverse_max_ms    = 200;
    plan.ground_filter_ms  = 0;
    load_settings(plan);

    // Code extremes and both edges of the reversed window, with the timestamp crossing the
    // wrap from all ones to zero.
    stamp_ms = 32'hFFFF_FFFC;
    send_sample(0, stamp_ms, 1'b0);
    stamp_ms++;
    send_sample(CODE_TOP, stamp_ms, 1'b1);
    stamp_ms++;
    send_sample(REV_LO_CODE, stamp_ms, 1'b0);
    stamp_ms++;
    send_sample(REV_HI_CODE, stamp_ms, 1'b1);
    stamp_ms++;
    send_sample(REV_HI_CODE + 1, stamp_ms, 1'b0);
    stamp_ms++;
    send_sample(REV_LO_CODE - 1, stamp_ms, 1'b1);

    if (settle_reversed) begin
      // A reversed reading held past the line filter: the reversal is reported once.
      repeat (5) begin
        stamp_ms = stamp_ms + 10;
        send_sample(REV_MID_CODE, stamp_ms, 1'b1);
      end
    end else begin
      // Readings that flip every sample never settle, so the check limit expires and the
      // line is taken as normal.
      for (int k = 0; k < 14; k++) begin
        stamp_ms = stamp_ms + 16;
        send_sample((k % 2 == 0) ? REV_MID_CODE : 0, stamp_ms, 1'b0);
      end
    end

    // Ground with a zero filter, on a normal line: an open reading latches the fault on its
    // second sample; a connected reading clears it only with the pilot high, not low.
    send_sample(CODE_TOP, stamp_ms, 1'b1);
    send_sample(CODE_TOP, stamp_ms, 1'b1);
    stamp_ms++;
    send_sample(100, stamp_ms, 1'b0);
    stamp_ms++;
    send_sample(100, stamp_ms, 1'b0);
    stamp_ms++;
    send_sample(100, stamp_ms, 1'b1);
    wait_for_results();

    // Random phases, each under its own register set. The long receiver hold-off comes in
    // one phase, and the last phase runs with no idling on either side.
    for (phase = 1; phase <= NUM_PHASES; phase++) begin
      plan = pick_settings(phase);
      load_settings(plan);
      if (phase == HOLD_PHASE) hold_off_req = 1'b1;
      if (phase == NUM_PHASES) calm = 1'b1;
      phase_start = samples_sent;
      while (samples_sent - phase_start < PHASE_ITEMS) send_burst(plan);
      wait_for_results();
    end

    $display("Checked %0d results from %0d samples under %0d register sets.",
             compared_results, samples_sent, NUM_PHASES + 1);
    $display("The line was first judged %s.",
             settle_reversed ? "reversed" : "normal after the check limit");
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
hdl/lgfm_pkg.sv
hdl/lgfm_cfg.sv
hdl/lgfm_core.sv
hdl/line_and_ground_fault_monitor_top.sv
tb/lgfm_checker.sv
tb/tb_top.sv
